/* sv/cfd_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 step for the CRC-32 frame deframer.
// No dependencies; every other file imports this package.
package cfd_pkg;

    // Frame limits and field widths
    localparam int MAX_PAYLOAD_BYTES = 256;
    localparam int POS_W             = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int LEN_FIELD_W       = 16;
    localparam int SEQ_W             = 16;
    localparam int FRAME_LEN_W       = 9;
    localparam int INDEX_W           = 8;
    localparam int STATUS_W          = 2;
    localparam int RX_CRC_W          = 24;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;

    // Frame verdict codes
    localparam logic [STATUS_W-1:0] STAT_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_GOOD = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEAD,
        PH_DATA,
        PH_CRC
    } phase_t;

    // One classified byte on its way from front to back
    typedef struct packed {
        logic [7:0] byte_val;
        logic       match_first;
        logic       match_second;
    } rx_item_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

    // One byte through the reflected CRC-32, eight shifts unrolled
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

endpackage

/* sv/cfd_front.sv */
// Front end of the deframer: configuration registers, input handshake and start-byte
// classification of each received byte. Depends on cfd_pkg.
module cfd_front
    import cfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_byte,
    input  queue_status_t         q_status,
    output logic                  push,
    output rx_item_t              push_item
);

    logic [7:0] start_first_reg;
    logic [7:0] start_first_next;
    logic [7:0] start_second_reg;
    logic [7:0] start_second_next;

    // Register writes; unknown indexes are dropped
    always_comb
    begin
        start_first_next  = start_first_reg;
        start_second_next = start_second_reg;
        if (cfg_write)
        begin
            if (cfg_index == CFG_START_FIRST)
            begin
                start_first_next = cfg_data;
            end
            else if (cfg_index == CFG_START_SECOND)
            begin
                start_second_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= 8'd0;
            start_second_reg <= 8'd0;
        end
        else
        begin
            start_first_reg  <= start_first_next;
            start_second_reg <= start_second_next;
        end
    end

    // Accept while the queue has room; tag the byte with its start matches
    assign in_stall               = q_status.full;
    assign push                   = in_valid && !q_status.full;
    assign push_item.byte_val     = in_byte;
    assign push_item.match_first  = (in_byte == start_first_reg);
    assign push_item.match_second = (in_byte == start_second_reg);

endmodule

/* sv/cfd_queue.sv */
// Short queue of classified bytes between the deframer's front and back.
// Depends on cfd_pkg.
module cfd_queue
    import cfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rx_item_t      push_item,
    input  logic          pop,
    output queue_status_t q_status,
    output rx_item_t      pop_item
);

    rx_item_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item       = entry_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = (count_reg == FULL_CNT);

endmodule

/* sv/cfd_back.sv */
// Back end of the deframer: frame parser, running CRC-32 and the output register.
// Depends on cfd_pkg.
module cfd_back
    import cfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  queue_status_t          q_status,
    input  rx_item_t               pop_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    frame_status,
    output logic [SEQ_W-1:0]       frame_seq,
    output logic [FRAME_LEN_W-1:0] frame_len,
    output logic                   payload_valid,
    output logic [7:0]             payload_byte,
    output logic [INDEX_W-1:0]     payload_index
);

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [1:0]              cnt_reg;
    logic [1:0]              cnt_next;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic [SEQ_W-1:0]        seq_reg;
    logic [SEQ_W-1:0]        seq_next;
    logic [LEN_FIELD_W-1:0]  len_reg;
    logic [LEN_FIELD_W-1:0]  len_next;
    logic [31:0]             crc_reg;
    logic [31:0]             crc_next;
    logic [RX_CRC_W-1:0]     rx_crc_reg;
    logic [RX_CRC_W-1:0]     rx_crc_next;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;
    logic                    pvalid_reg;
    logic                    pvalid_next;
    logic [7:0]              pbyte_reg;
    logic [7:0]              pbyte_next;
    logic [INDEX_W-1:0]      pindex_reg;
    logic [INDEX_W-1:0]      pindex_next;

    logic [7:0]              b;
    logic [LEN_FIELD_W-1:0]  hdr_len;
    logic [POS_W-1:0]        pos_inc;
    logic [31:0]             crc_upd;
    logic [31:0]             rx_full;

    // Take the next byte when the output slot is free or being emptied
    assign pop = q_status.valid && (!out_valid_reg || !out_stall);

    assign b       = pop_item.byte_val;
    assign hdr_len = {b, rx_crc_reg[23:16]};
    assign pos_inc = pos_reg + 1'b1;
    assign crc_upd = crc32_byte(crc_reg, b);
    assign rx_full = {b, rx_crc_reg};

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT2:
            begin
                if (pop_item.match_second)
                begin
                    phase_next = PH_HEAD;
                end
                else
                begin
                    phase_next = pop_item.match_first ? PH_HUNT2 : PH_HUNT1;
                end
            end
            PH_HEAD:
            begin
                if (cnt_reg == 2'd3)
                begin
                    if (hdr_len > LEN_FIELD_W'(MAX_PAYLOAD_BYTES))
                    begin
                        phase_next = PH_HUNT1;
                    end
                    else
                    begin
                        phase_next = (hdr_len == '0) ? PH_CRC : PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (LEN_FIELD_W'(pos_inc) >= len_reg)
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (cnt_reg == 2'd3)
                begin
                    phase_next = PH_HUNT1;
                end
            end
            default:
            begin
                phase_next = pop_item.match_first ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    // Datapath and result fields
    always_comb
    begin
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        status_next = STAT_NONE;
        pvalid_next = 1'b0;
        pbyte_next  = 8'd0;
        pindex_next = '0;
        unique case (phase_reg)
            PH_HUNT2:
            begin
                if (pop_item.match_second)
                begin
                    cnt_next    = 2'd0;
                    crc_next    = CRC_INIT;
                    rx_crc_next = '0;
                end
            end
            PH_HEAD:
            begin
                crc_next = crc_upd;
                if (cnt_reg != 2'd3)
                begin
                    rx_crc_next[{cnt_reg, 3'b000} +: 8] = b;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    seq_next    = rx_crc_reg[15:0];
                    len_next    = hdr_len;
                    pos_next    = '0;
                    cnt_next    = 2'd0;
                    rx_crc_next = '0;
                end
            end
            PH_DATA:
            begin
                crc_next    = crc_upd;
                pvalid_next = 1'b1;
                pbyte_next  = b;
                pindex_next = INDEX_W'(pos_reg);
                pos_next    = pos_inc;
                if (LEN_FIELD_W'(pos_inc) >= len_reg)
                begin
                    cnt_next    = 2'd0;
                    rx_crc_next = '0;
                end
            end
            PH_CRC:
            begin
                if (cnt_reg != 2'd3)
                begin
                    rx_crc_next[{cnt_reg, 3'b000} +: 8] = b;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    status_next = (rx_full == ~crc_reg) ? STAT_GOOD : STAT_BAD;
                    cnt_next    = 2'd0;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            cnt_reg    <= 2'd0;
            pos_reg    <= '0;
            seq_reg    <= '0;
            len_reg    <= '0;
            crc_reg    <= CRC_INIT;
            rx_crc_reg <= '0;
        end
        else if (pop)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            seq_reg    <= seq_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            pvalid_reg <= pvalid_next;
            pbyte_reg  <= pbyte_next;
            pindex_reg <= pindex_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_status  = status_reg;
    assign frame_seq     = seq_reg;
    assign frame_len     = len_reg[FRAME_LEN_W-1:0];
    assign payload_valid = pvalid_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_index = pindex_reg;

endmodule

/* sv/crc32_frame_deframer.sv */
// Byte-serial deframer for CRC-32 protected frames: one received byte in, one result out,
// sustained at one byte per clock while out_stall is low and the queue has room. A byte is
// accepted while the two-entry queue behind the front end has room; the queue is written at
// the accepting edge and the parser loads the output register once it is free or being
// emptied, so each result on out_valid is registered. The rate is set by the parser's
// byte-wide CRC-32 update, eight reflected shifts unrolled. frame_seq and frame_len show the
// most recently decoded header and are read together with each result. Payload bytes are
// passed out as they arrive; a result with frame_status bad tells the consumer to drop the
// frame. Depends on cfd_pkg, cfd_front, cfd_queue and cfd_back.
module crc32_frame_deframer
    import cfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    frame_status,
    output logic [SEQ_W-1:0]       frame_seq,
    output logic [FRAME_LEN_W-1:0] frame_len,
    output logic                   payload_valid,
    output logic [7:0]             payload_byte,
    output logic [INDEX_W-1:0]     payload_index
);

    queue_status_t q_status;
    logic          push;
    rx_item_t      push_item;
    logic          pop;
    rx_item_t      pop_item;

    cfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    cfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_status  (q_status),
        .pop_item  (pop_item)
    );

    cfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop_item      (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_status  (frame_status),
        .frame_seq     (frame_seq),
        .frame_len     (frame_len),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index)
    );

    // A verdict never rides on a payload byte
    a_verdict_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> frame_status == STAT_NONE)
        else $error("verdict reported on a payload byte");

    // Only the three defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_status == STAT_NONE || frame_status == STAT_GOOD ||
                       frame_status == STAT_BAD))
        else $error("undefined frame status code");

    // Non-payload results carry zeroed payload fields
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == '0)
        else $error("payload fields set on a non-payload result");

    // The queue never takes a byte while full
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("push into a full queue");

endmodule

/* test/crc32_frame_deframer_test.sv */
// Self-checking testbench for crc32_frame_deframer: random and directed byte streams with
// random idling on both sides, checked byte by byte against an in-bench parser model.
// Depends on cfd_pkg and the crc32_frame_deframer RTL.
module crc32_frame_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cfd_pkg::*;

    // Register indexes past the two start bytes; the block ignores writes to them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int MAX_WAIT     = 19;
    localparam int REPORT_LIMIT = 50;
    localparam int PHASE_BYTES  = 190;

    // One result of the deframer, as predicted per accepted byte
    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [SEQ_W-1:0]       seq;
        logic [FRAME_LEN_W-1:0] len;
        logic                   pvalid;
        logic [7:0]             pbyte;
        logic [INDEX_W-1:0]     pindex;
    } deframe_out_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             in_byte = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STATUS_W-1:0]    frame_status;
    logic [SEQ_W-1:0]       frame_seq;
    logic [FRAME_LEN_W-1:0] frame_len;
    logic                   payload_valid;
    logic [7:0]             payload_byte;
    logic [INDEX_W-1:0]     payload_index;

    // Bytes waiting to be sent and outputs waiting to arrive
    logic [7:0]   link_bytes[$];
    deframe_out_t deframe_outputs[$];
    int           mismatch_count = 0;

    // Parser model: configuration and state
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    phase_t      rx_phase;
    logic [15:0] rx_pos;
    logic [15:0] rx_seq;
    logic [15:0] rx_len;
    logic [31:0] rx_crc;
    logic [31:0] rx_stash;
    logic [1:0]  rx_crc_cnt;

    // Idling state of each side
    int tx_gap = 0;
    int rx_hold = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    crc32_frame_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_status  (frame_status),
        .frame_seq     (frame_seq),
        .frame_len     (frame_len),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reflected CRC-32, one input bit at a time
    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void reset_parser();
        sync_first  = '0;
        sync_second = '0;
        rx_phase    = PH_HUNT1;
        rx_pos      = '0;
        rx_seq      = '0;
        rx_len      = '0;
        rx_crc      = CRC_INIT;
        rx_stash    = '0;
        rx_crc_cnt  = '0;
    endfunction

    // Advance the parser model by one received byte and queue the output it gives
    function automatic void deframe_byte(input logic [7:0] b);
        deframe_out_t r;
        r.status = STAT_NONE;
        r.pvalid = 1'b0;
        r.pbyte  = '0;
        r.pindex = '0;
        case (rx_phase)
            PH_HUNT2:
            begin
                // a second-byte match wins; a repeated first byte keeps the hunt going
                if (b == sync_second)
                begin
                    rx_phase = PH_HEAD;
                    rx_pos   = '0;
                    rx_crc   = CRC_INIT;
                    rx_stash = '0;
                end
                else
                    rx_phase = (b == sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
            PH_HEAD:
            begin
                rx_crc = crc_update(rx_crc, b);
                if (rx_pos < 3)
                begin
                    rx_stash = rx_stash | (32'(b) << (8 * rx_pos));
                    rx_pos   = rx_pos + 16'd1;
                end
                else
                begin
                    rx_seq     = rx_stash[15:0];
                    rx_len     = {b, rx_stash[23:16]};
                    rx_pos     = '0;
                    rx_crc_cnt = '0;
                    rx_stash   = '0;
                    // oversized length: drop back to the hunt without a verdict
                    if (rx_len > MAX_PAYLOAD_BYTES)
                        rx_phase = PH_HUNT1;
                    else if (rx_len == 0)
                        rx_phase = PH_CRC;
                    else
                        rx_phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                rx_crc   = crc_update(rx_crc, b);
                r.pvalid = 1'b1;
                r.pbyte  = b;
                r.pindex = rx_pos[INDEX_W-1:0];
                rx_pos   = rx_pos + 16'd1;
                if (rx_pos >= rx_len)
                begin
                    rx_crc_cnt = '0;
                    rx_stash   = '0;
                    rx_phase   = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (rx_crc_cnt < 3)
                begin
                    rx_stash   = rx_stash | (32'(b) << (8 * rx_crc_cnt));
                    rx_crc_cnt = rx_crc_cnt + 2'd1;
                end
                else
                begin
                    r.status   = ({b, rx_stash[23:0]} == ~rx_crc) ? STAT_GOOD : STAT_BAD;
                    rx_crc_cnt = '0;
                    rx_phase   = PH_HUNT1;
                end
            end
            default:
                rx_phase = (b == sync_first) ? PH_HUNT2 : PH_HUNT1;
        endcase
        r.seq = rx_seq;
        r.len = rx_len[FRAME_LEN_W-1:0];
        deframe_outputs.push_back(r);
    endfunction

    // Build one frame with the current start bytes; oversized lengths get no body
    function automatic void queue_frame(input logic [15:0] seq, input logic [15:0] len,
                                        input bit corrupt);
        logic [31:0] c;
        logic [31:0] fcs;
        logic [7:0]  hdr[4];
        logic [7:0]  b;
        hdr = '{seq[7:0], seq[15:8], len[7:0], len[15:8]};
        c   = CRC_INIT;
        link_bytes.push_back(sync_first);
        link_bytes.push_back(sync_second);
        for (int i = 0; i < 4; i++)
        begin
            link_bytes.push_back(hdr[i]);
            c = crc_update(c, hdr[i]);
        end
        if (len <= MAX_PAYLOAD_BYTES)
        begin
            for (int i = 0; i < len; i++)
            begin
                b = 8'($urandom);
                link_bytes.push_back(b);
                c = crc_update(c, b);
            end
            fcs = ~c;
            if (corrupt)
                fcs[5'($urandom_range(0, 31))] ^= 1'b1;
            for (int i = 0; i < 4; i++)
                link_bytes.push_back(fcs[8*i +: 8]);
        end
    endfunction

    function automatic logic [15:0] pick_length();
        int k;
        k = $urandom_range(0, 99);
        if (k < 8)
            return 16'd0;
        else if (k < 12)
            return 16'd1;
        else if (k < 14)
            return 16'(MAX_PAYLOAD_BYTES);
        else
            return 16'($urandom_range(2, 16));
    endfunction

    // Mostly well-formed frames, plus bad CRCs, oversized lengths, cut frames and noise
    function automatic void fill_random(input int target);
        int base;
        int kind;
        int n;
        base = link_bytes.size();
        while (link_bytes.size() - base < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
                queue_frame(16'($urandom), pick_length(), 1'b0);
            else if (kind < 77)
                queue_frame(16'($urandom), pick_length(), 1'b1);
            else if (kind < 82)
                queue_frame(16'($urandom),
                            16'($urandom_range(MAX_PAYLOAD_BYTES + 1, 65535)), 1'b0);
            else if (kind < 90)
            begin
                link_bytes.push_back(sync_first);
                link_bytes.push_back(sync_second);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                    link_bytes.push_back(8'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    link_bytes.push_back(($urandom_range(0, 3) == 0) ? sync_first
                                                                     : 8'($urandom));
            end
        end
    endfunction

    function automatic int pick_wait(input bit steady);
        return steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Write all four register indexes; the block must be idle
    task automatic write_config(input logic [7:0] first_val, input logic [7:0] second_val);
        cfg_write <= 1'b1;
        cfg_index <= CFG_START_FIRST;
        cfg_data  <= first_val;
        @(posedge clk);
        cfg_index <= CFG_START_SECOND;
        cfg_data  <= second_val;
        @(posedge clk);
        cfg_index <= CFG_SPARE_LO;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_index <= CFG_SPARE_HI;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        sync_first  = first_val;
        sync_second = second_val;
    endtask

    // Wait until every byte is sent and every output has come back
    task automatic drain();
        wait (link_bytes.size() == 0 && !in_valid && deframe_outputs.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        if (mismatch_count < REPORT_LIMIT)
            $display("ERROR %0t ns: %s got %0h expected %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_output();
        deframe_out_t want;
        if (deframe_outputs.size() == 0)
        begin
            report("output with no request outstanding, frame_status",
                   32'(frame_status), 32'd0);
            return;
        end
        want = deframe_outputs.pop_front();
        if (frame_status !== want.status)
            report("frame_status", 32'(frame_status), 32'(want.status));
        if (frame_seq !== want.seq)
            report("frame_seq", 32'(frame_seq), 32'(want.seq));
        if (frame_len !== want.len)
            report("frame_len", 32'(frame_len), 32'(want.len));
        if (payload_valid !== want.pvalid)
            report("payload_valid", 32'(payload_valid), 32'(want.pvalid));
        if (payload_byte !== want.pbyte)
            report("payload_byte", 32'(payload_byte), 32'(want.pbyte));
        if (payload_index !== want.pindex)
            report("payload_index", 32'(payload_index), 32'(want.pindex));
    endtask

    // Request driver: predicts on each accepted byte, then idles or sends the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= '0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                deframe_byte(in_byte);
            if (!(in_valid && in_stall))
            begin
                if (tx_gap != 0)
                begin
                    tx_gap = tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (link_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= link_bytes.pop_front();
                    if ($urandom_range(0, 47) == 0)
                        tx_steady = !tx_steady;
                    tx_gap = pick_wait(tx_steady);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each accepted output, then stalls for a drawn count
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_hold = 0;
        end
        else if (out_valid && !out_stall)
        begin
            check_output();
            if ($urandom_range(0, 47) == 0)
                rx_steady = !rx_steady;
            rx_hold = pick_wait(rx_steady);
            out_stall <= (rx_hold != 0);
        end
        else if (rx_hold != 0)
        begin
            rx_hold = rx_hold - 1;
            out_stall <= (rx_hold != 0);
        end
    end

    // Stimulus: one phase per start-byte setting, directed bytes first in phases 0 and 1
    initial
    begin
        logic [7:0] pa;
        logic [7:0] pb;
        reset_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:       begin pa = 8'hA5; pb = 8'h5A; end
                1:       begin pa = 8'h00; pb = 8'hFF; end
                2:       begin pa = 8'hFF; pb = 8'h00; end
                3:       begin pa = 8'hFF; pb = 8'hFF; end
                4:       begin pa = 8'h00; pb = 8'h00; end
                5:       begin pa = 8'($urandom); pb = 8'($urandom); end
                default: begin pa = 8'($urandom); pb = pa; end
            endcase
            write_config(pa, pb);
            if (phase == 0)
            begin
                // repeated first byte, zero-length frame with the extreme sequence number
                link_bytes.push_back(sync_first);
                queue_frame(16'hFFFF, 16'd0, 1'b0);
                // second start byte wrong
                link_bytes.push_back(sync_first);
                link_bytes.push_back(8'hFF);
                // largest length field, far past the limit
                queue_frame(16'h0000, 16'hFFFF, 1'b0);
                // one payload byte, damaged check word
                queue_frame(16'h8001, 16'd1, 1'b1);
            end
            else if (phase == 1)
                queue_frame(16'($urandom), 16'(MAX_PAYLOAD_BYTES), 1'b0);
            fill_random(PHASE_BYTES);
            drain();
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("crc32_frame_deframer: match");
        else
            $display("crc32_frame_deframer: mismatch");
        $finish;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("crc32_frame_deframer: mismatch");
        $finish;
    end

endmodule
